[sv/indexed_list_insert_remove_defines.svh]
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define ILIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define ILIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ilir_pkg.sv]
`default_nettype none

package ilir_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned STATUS_W     = 2;
    // index width that covers every legal capacity (up to 256 plus the count itself)
    localparam int unsigned IDX_W        = 9;

    localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE_VAL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              rem_at;
        logic              rem_val;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/ilir_cell.sv]
`default_nettype none

module ilir_cell
    import ilir_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  wire logic              aclk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    input  wire logic              found_in,
    input  wire logic [DATA_W-1:0] taken_in,
    output logic      [DATA_W-1:0] data,
    output logic                   found_out,
    output logic      [DATA_W-1:0] taken_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              valid;
    logic              match;

    assign valid     = MY_IDX < ctrl.count;
    assign match     = valid && (data_reg == ctrl.value);
    // set at and after the first equal entry
    assign found_out = found_in || match;
    assign taken_out = taken_in
                     | ((ctrl.rem_at && (MY_IDX == ctrl.pos)) ? data_reg : '0);
    assign data      = data_reg;

    always_comb begin
        data_next = data_reg;
        priority if (ctrl.ins && (MY_IDX == ctrl.pos)) begin
            data_next = ctrl.value;
        end else if (ctrl.ins && (MY_IDX > ctrl.pos)) begin
            data_next = left_data;
        end else if (ctrl.rem_at && (MY_IDX >= ctrl.pos)) begin
            data_next = right_data;
        end else if (ctrl.rem_val && found_out) begin
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

[sv/indexed_list_insert_remove.sv]
// channel  | dir | handshake                    | tdata fields (lsb first)
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | kind[2:0] position[7:3] value[39:8]
// m_axis   | out | m_axis_tvalid/m_axis_tready  | status[1:0] removed_value[33:2]
//          |     |                              | entry_count[38:34] zero pad[39]
//
// one request per cycle while s_axis_tready is high, result in the cycle after acceptance from the output register
// every cell shifts, loads or compares in the same cycle, so the row settles each edge
// s_axis_tready drops only while a result waits and m_axis_tready is low
// aresetn (synchronous, active low) empties the list and drops m_axis_tvalid
// stored entries have no reset, only entries below the count are ever read
`default_nettype none
`include "indexed_list_insert_remove_defines.svh"

module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request: kind[2:0] position[7:3] value[39:8]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // result: status[1:0] removed_value[33:2] entry_count[38:34] pad[39]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] CAP_X = IDX_W'(CAPACITY);

    // request fields
    logic [KIND_W-1:0] s_kind;
    logic [POS_W-1:0]  s_position;
    logic [DATA_W-1:0] s_value;

    assign s_kind     = s_axis_tdata[2:0];
    assign s_position = s_axis_tdata[7:3];
    assign s_value    = s_axis_tdata[39:8];

    // control and count
    logic             s_acc;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] cnt_x;
    logic [IDX_W-1:0] pos_x;
    logic             full;
    cell_ctrl_t       ctrl;

    // result register
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   removed_reg;
    logic [DATA_W-1:0]   removed_next;
    logic [POS_W-1:0]    count_out_reg;

    // the row of cells
    logic [DATA_W-1:0] cell_data  [CAPACITY];
    logic [DATA_W-1:0] cell_left  [CAPACITY];
    logic [DATA_W-1:0] cell_right [CAPACITY];
    logic              found_c    [CAPACITY+1];
    logic [DATA_W-1:0] taken_c    [CAPACITY+1];

    // a result may leave while the next request is taken
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign cnt_x = IDX_W'(cnt_reg);
    assign pos_x = IDX_W'(s_position);
    assign full  = cnt_x >= CAP_X;

    // decode the request; cells move only on an accepted, legal request
    always_comb begin
        ctrl         = '0;
        ctrl.count   = cnt_x;
        ctrl.value   = s_value;
        ctrl.pos     = pos_x;
        status_next  = STATUS_OK;
        removed_next = '0;
        cnt_next     = cnt_reg;
        unique case (s_kind)
            KIND_APPEND: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ctrl.ins = s_acc;
                    ctrl.pos = cnt_x;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            KIND_INSERT: begin
                // the position test wins over the full test
                if (pos_x > cnt_x) begin
                    status_next = STATUS_BAD_POS;
                end else if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ctrl.ins = s_acc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            KIND_REMOVE_AT: begin
                if (pos_x >= cnt_x) begin
                    status_next = STATUS_BAD_POS;
                end else begin
                    ctrl.rem_at  = s_acc;
                    removed_next = taken_c[CAPACITY];
                    cnt_next     = cnt_reg - 1'b1;
                end
            end
            KIND_REMOVE_VAL: begin
                // no match means no cell shifts
                ctrl.rem_val = s_acc;
                if (found_c[CAPACITY]) begin
                    // the entry taken out equals the search value
                    removed_next = s_value;
                    cnt_next     = cnt_reg - 1'b1;
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            KIND_CLEAR: begin
                cnt_next = '0;
            end
            default: begin
                // unused kinds leave everything as it is
                cnt_next = cnt_reg;
            end
        endcase
    end

    // found and taken travel from cell 0 upward
    assign found_c[0] = 1'b0;
    assign taken_c[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign cell_left[i] = '0;
        end else begin : g_mid_left
            assign cell_left[i] = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign cell_right[i] = cell_data[i];
        end else begin : g_mid_right
            assign cell_right[i] = cell_data[i+1];
        end

        ilir_cell #(
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .left_data  (cell_left[i]),
            .right_data (cell_right[i]),
            .found_in   (found_c[i]),
            .taken_in   (taken_c[i]),
            .data       (cell_data[i]),
            .found_out  (found_c[i+1]),
            .taken_out  (taken_c[i+1])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_acc) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_acc) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            count_out_reg <= POS_W'(cnt_next);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, count_out_reg, removed_reg, status_reg};

    // checks
    `ILIR_ASSERT_NOW(a_count_in_range, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ILIR_ASSERT_NOW(a_removed_zero_on_fail, m_valid_reg && (status_reg != STATUS_OK), removed_reg == '0, "removed value set on a failed request")
    `ILIR_ASSERT_NEXT(a_clear_empties, s_acc && (s_kind == KIND_CLEAR), (cnt_reg == '0) && (count_out_reg == '0), "clear did not empty the list")
    `ILIR_ASSERT_NEXT(a_full_holds_count, s_acc && full && (s_kind == KIND_APPEND), (cnt_reg == $past(cnt_reg)) && (status_reg == STATUS_FULL), "append on full list changed the count")

endmodule

`default_nettype wire
